// ===== hdl/bte_pkg.sv =====
// Shared types, constants and helpers for the box tracking-error value function.
`default_nettype none

package bte_pkg;

    // Number of axes; the top level names one port per axis (x, y, z).
    localparam int AXES = 3;

    // Configuration register indexes: axis settings first, then the priority pair.
    localparam int CFG_COUNT     = AXES + 2;
    localparam int CFG_IDX_W     = $clog2(CFG_COUNT);
    localparam int CFG_PRIO_LOW  = AXES;
    localparam int CFG_PRIO_SPAN = AXES + 1;

    // Field widths.
    localparam int IN_W    = 16;
    localparam int SET_W   = 48;
    localparam int PRIO_W  = 17;
    localparam int OUT_W   = 32;
    localparam int SURF_W  = 54;

    // Pipeline depth: five lane stages and three merge stages.
    localparam int LANE_STAGES  = 5;
    localparam int MERGE_STAGES = 3;
    localparam int LATENCY      = LANE_STAGES + MERGE_STAGES;

    // Priority one in unsigned Q1.16.
    localparam logic [PRIO_W-1:0] PRIO_ONE = 17'h10000;

    // One axis register: inverse effective acceleration, position expansion,
    // planner speed, each unsigned Q8.8.
    typedef struct packed {
        logic [15:0] k;
        logic [15:0] pe;
        logic [15:0] vp;
    } axis_settings_t;

    // What one lane hands to the merge stage.
    typedef struct packed {
        logic signed [SURF_W-1:0] surf;
        logic                     side;
        logic signed [OUT_W-1:0]  grad;
    } lane_out_t;

    // Saturate a signed value to 32 bits.
    function automatic logic signed [OUT_W-1:0] sat32(input logic signed [63:0] a);
        logic signed [OUT_W-1:0] r;
        if (a > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (a < -64'sh0000_0000_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = a[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/bte_lane.sv =====
// One axis lane: relative state, both parabolic surfaces, side and velocity gradient.
`default_nettype none

module bte_lane (
    input  wire logic                          clk,
    input  wire logic signed [15:0]            tracker_pos,
    input  wire logic signed [15:0]            tracker_vel,
    input  wire logic signed [15:0]            planner_pos,
    input  wire logic signed [15:0]            planner_vel,
    input  wire bte_pkg::axis_settings_t       settings,
    output bte_pkg::lane_out_t                 lane_out
);

    // Stage 1: relative position plus expansion, velocity offsets.
    logic signed [16:0] x_diff;
    logic signed [16:0] v_diff;
    logic signed [17:0] xpe_next, dm_next, dp_next;
    logic signed [17:0] xpe1_reg, dm_reg, dp_reg;

    // Stage 2: squares and gradient products.
    logic signed [35:0] sqm_full, sqp_full;
    logic [34:0]        sqm_reg, sqp_reg;
    logic [31:0]        vsq_next, vsq_reg;
    logic signed [34:0] gm_next, gp_next, gm2_reg, gp2_reg;
    logic signed [17:0] xpe2_reg;

    // Stage 3: quadratic terms before scaling by k.
    logic signed [36:0] qa_next, qb_next, qa_reg, qb_reg;
    logic signed [34:0] gm3_reg, gp3_reg;
    logic signed [17:0] xpe3_reg;

    // Stage 4: split products with k.
    logic [33:0]        pa_lo_next, pb_lo_next, pa_lo_reg, pb_lo_reg;
    logic signed [35:0] pa_hi_next, pb_hi_next, pa_hi_reg, pb_hi_reg;
    logic signed [34:0] gm4_reg, gp4_reg;
    logic signed [17:0] xpe4_reg;

    // Stage 5: surfaces, compare, select.
    logic signed [53:0] xs, sa, sb;
    logic               a_side;
    bte_pkg::lane_out_t out_next, out_reg;

    always_comb
    begin
        x_diff   = 17'(tracker_pos) - 17'(planner_pos);
        v_diff   = 17'(tracker_vel) - 17'(planner_vel);
        xpe_next = 18'(x_diff) + $signed({2'b00, settings.pe});
        dm_next  = 18'(v_diff) - $signed({2'b00, settings.vp});
        dp_next  = 18'(v_diff) + $signed({2'b00, settings.vp});

        sqm_full = 36'(dm_reg) * 36'(dm_reg);
        sqp_full = 36'(dp_reg) * 36'(dp_reg);
        vsq_next = 32'(settings.vp) * 32'(settings.vp);
        gm_next  = 35'(dm_reg) * 35'($signed({1'b0, settings.k}));
        gp_next  = 35'(dp_reg) * 35'($signed({1'b0, settings.k}));

        qa_next = $signed({2'b00, sqm_reg}) - $signed({4'b0000, vsq_reg, 1'b0});
        qb_next = $signed({2'b00, sqp_reg}) - $signed({4'b0000, vsq_reg, 1'b0});

        pa_lo_next = {16'b0, qa_reg[17:0]} * {18'b0, settings.k};
        pb_lo_next = {16'b0, qb_reg[17:0]} * {18'b0, settings.k};
        pa_hi_next = 36'($signed(qa_reg[36:18])) * 36'($signed({1'b0, settings.k}));
        pb_hi_next = 36'($signed(qb_reg[36:18])) * 36'($signed({1'b0, settings.k}));

        xs = $signed({{19{xpe4_reg[17]}}, xpe4_reg, 17'b0});
        sa = $signed({pa_hi_reg, 18'b0}) + $signed({20'b0, pa_lo_reg}) - xs;
        sb = $signed({pb_hi_reg, 18'b0}) + $signed({20'b0, pb_lo_reg}) + xs;
        a_side = sa > sb;

        out_next.surf = a_side ? sa : sb;
        out_next.side = ~a_side;
        out_next.grad = a_side ? bte_pkg::sat32(64'(gm4_reg))
                               : bte_pkg::sat32(64'(gp4_reg));
    end

    always_ff @(posedge clk)
    begin
        xpe1_reg <= xpe_next;
        dm_reg   <= dm_next;
        dp_reg   <= dp_next;

        sqm_reg  <= sqm_full[34:0];
        sqp_reg  <= sqp_full[34:0];
        vsq_reg  <= vsq_next;
        gm2_reg  <= gm_next;
        gp2_reg  <= gp_next;
        xpe2_reg <= xpe1_reg;

        qa_reg   <= qa_next;
        qb_reg   <= qb_next;
        gm3_reg  <= gm2_reg;
        gp3_reg  <= gp2_reg;
        xpe3_reg <= xpe2_reg;

        pa_lo_reg <= pa_lo_next;
        pb_lo_reg <= pb_lo_next;
        pa_hi_reg <= pa_hi_next;
        pb_hi_reg <= pb_hi_next;
        gm4_reg   <= gm3_reg;
        gp4_reg   <= gp3_reg;
        xpe4_reg  <= xpe3_reg;

        out_reg <= out_next;
    end

    assign lane_out = out_reg;

endmodule

`default_nettype wire

// ===== hdl/bte_merge.sv =====
// Merge stage: largest surface over the lanes, rounding, saturation and priority.
`default_nettype none

module bte_merge (
    input  wire logic                              clk,
    input  wire bte_pkg::lane_out_t                lanes [bte_pkg::AXES],
    input  wire logic [31:0]                       prio_low,
    input  wire logic [31:0]                       prio_span,
    output logic signed [bte_pkg::OUT_W-1:0]       value,
    output logic [bte_pkg::PRIO_W-1:0]             prio,
    output logic [bte_pkg::AXES-1:0]               side,
    output logic signed [bte_pkg::OUT_W-1:0]       grad [bte_pkg::AXES]
);

    logic signed [bte_pkg::SURF_W-1:0] best;
    logic signed [44:0]                shifted;
    logic signed [bte_pkg::OUT_W-1:0]  value_next, value1_reg, value2_reg, value_reg;
    logic [bte_pkg::AXES-1:0]          side1_reg, side2_reg, side_reg;
    logic signed [bte_pkg::OUT_W-1:0]  grad1_reg [bte_pkg::AXES];
    logic signed [bte_pkg::OUT_W-1:0]  grad2_reg [bte_pkg::AXES];
    logic signed [bte_pkg::OUT_W-1:0]  grad_reg  [bte_pkg::AXES];
    logic signed [33:0]                diff;
    logic                              pos_next, pos_reg;
    logic [62:0]                       prod_next, prod_reg;
    logic [46:0]                       excess;
    logic [bte_pkg::PRIO_W-1:0]        prio_next, prio_reg;

    always_comb
    begin
        best = lanes[0].surf;
        for (int i = 1; i < bte_pkg::AXES; i++)
        begin
            if (lanes[i].surf > best)
            begin
                best = lanes[i].surf;
            end
        end
        // Arithmetic shift rounds toward minus infinity.
        shifted    = $signed(best[53:9]);
        value_next = bte_pkg::sat32(64'(shifted));

        diff      = 34'(value1_reg) - $signed({2'b00, prio_low});
        pos_next  = ~diff[33] && (diff != 34'sd0);
        prod_next = {32'b0, diff[30:0]} * {31'b0, prio_span};

        excess = prod_reg[62:16];
        if (!pos_reg)
        begin
            prio_next = bte_pkg::PRIO_ONE;
        end
        else if (excess >= 47'(bte_pkg::PRIO_ONE))
        begin
            prio_next = '0;
        end
        else
        begin
            prio_next = bte_pkg::PRIO_ONE - excess[16:0];
        end
    end

    always_ff @(posedge clk)
    begin
        value1_reg <= value_next;
        value2_reg <= value1_reg;
        value_reg  <= value2_reg;
        pos_reg    <= pos_next;
        prod_reg   <= prod_next;
        prio_reg   <= prio_next;
        side2_reg  <= side1_reg;
        side_reg   <= side2_reg;
        for (int i = 0; i < bte_pkg::AXES; i++)
        begin
            side1_reg[i] <= lanes[i].side;
            grad1_reg[i] <= lanes[i].grad;
            grad2_reg[i] <= grad1_reg[i];
            grad_reg[i]  <= grad2_reg[i];
        end
    end

    assign value = value_reg;
    assign prio  = prio_reg;
    assign side  = side_reg;
    assign grad  = grad_reg;

endmodule

`default_nettype wire

// ===== hdl/box_tracking_error_value_function.sv =====
// Top level of the box tracking-error value function: ports, registers, lanes and merge.
// A result is on the outputs, with done high, once its item has passed the five-stage
// lane pipeline and the three-stage merge pipeline; the receiver takes it while done is high.
// Throughput: one item per cycle; busy stays low, so start may be held high every cycle.
// The first lane stage loads at the edge that accepts the item.
// Reset clears the configuration registers to zero and empties the pipeline; results
// leave on done for one cycle each, and the receiver cannot stall them.
`default_nettype none

module box_tracking_error_value_function (
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    // Item handshake.
    input  wire logic                            start,
    output logic                                 busy,
    output logic                                 done,

    // Configuration write channel.
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [bte_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bte_pkg::SET_W-1:0]       cfg_data,

    // Item fields.
    input  wire logic signed [15:0]              tracker_pos_x,
    input  wire logic signed [15:0]              tracker_pos_y,
    input  wire logic signed [15:0]              tracker_pos_z,
    input  wire logic signed [15:0]              tracker_vel_x,
    input  wire logic signed [15:0]              tracker_vel_y,
    input  wire logic signed [15:0]              tracker_vel_z,
    input  wire logic signed [15:0]              planner_pos_x,
    input  wire logic signed [15:0]              planner_pos_y,
    input  wire logic signed [15:0]              planner_pos_z,
    input  wire logic signed [15:0]              planner_vel_x,
    input  wire logic signed [15:0]              planner_vel_y,
    input  wire logic signed [15:0]              planner_vel_z,

    // Result fields.
    output logic signed [31:0]                   value_out,
    output logic [16:0]                          priority_out,
    output logic                                 side_x,
    output logic                                 side_y,
    output logic                                 side_z,
    output logic signed [31:0]                   vel_gradient_x,
    output logic signed [31:0]                   vel_gradient_y,
    output logic signed [31:0]                   vel_gradient_z
);

    // Configuration registers. The user changes them only while the pipeline is empty;
    // the block does not enforce this; lanes and merge read them directly where needed.
    logic [bte_pkg::SET_W-1:0] axis_settings_reg [bte_pkg::AXES];
    logic [31:0]               prio_low_reg;
    logic [31:0]               prio_span_reg;

    // One valid bit per pipeline stage; the last one is the done strobe.
    logic [bte_pkg::LATENCY-1:0] valid_reg, valid_next;
    logic                        accept;

    // Per-axis views of the item ports so the lanes can be generated.
    logic signed [15:0] tp [bte_pkg::AXES];
    logic signed [15:0] tv [bte_pkg::AXES];
    logic signed [15:0] pp [bte_pkg::AXES];
    logic signed [15:0] pv [bte_pkg::AXES];

    bte_pkg::lane_out_t               lane_out [bte_pkg::AXES];
    logic signed [bte_pkg::OUT_W-1:0] grad     [bte_pkg::AXES];
    logic [bte_pkg::AXES-1:0]         side;

    // The pipeline never stalls, so a new item can enter every cycle.
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    assign tp[0] = tracker_pos_x;
    assign tp[1] = tracker_pos_y;
    assign tp[2] = tracker_pos_z;
    assign tv[0] = tracker_vel_x;
    assign tv[1] = tracker_vel_y;
    assign tv[2] = tracker_vel_z;
    assign pp[0] = planner_pos_x;
    assign pp[1] = planner_pos_y;
    assign pp[2] = planner_pos_z;
    assign pv[0] = planner_vel_x;
    assign pv[1] = planner_vel_y;
    assign pv[2] = planner_vel_z;

    // Register writes. An index past the last register is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < bte_pkg::AXES; i++)
            begin
                axis_settings_reg[i] <= '0;
            end
            prio_low_reg  <= '0;
            prio_span_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            for (int i = 0; i < bte_pkg::AXES; i++)
            begin
                if (cfg_index == bte_pkg::CFG_IDX_W'(i))
                begin
                    axis_settings_reg[i] <= cfg_data;
                end
            end
            if (cfg_index == bte_pkg::CFG_IDX_W'(bte_pkg::CFG_PRIO_LOW))
            begin
                prio_low_reg <= cfg_data[31:0];
            end
            if (cfg_index == bte_pkg::CFG_IDX_W'(bte_pkg::CFG_PRIO_SPAN))
            begin
                prio_span_reg <= cfg_data[31:0];
            end
        end
    end

    // Valid bits follow each item down the pipeline.
    assign valid_next = {valid_reg[bte_pkg::LATENCY-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign done = valid_reg[bte_pkg::LATENCY-1];

    // One lane per axis; each forms both surfaces of its axis and picks the larger.
    for (genvar g = 0; g < bte_pkg::AXES; g++)
    begin : g_lane
        bte_lane u_lane (
            .clk         (clk),
            .tracker_pos (tp[g]),
            .tracker_vel (tv[g]),
            .planner_pos (pp[g]),
            .planner_vel (pv[g]),
            .settings    (bte_pkg::axis_settings_t'(axis_settings_reg[g])),
            .lane_out    (lane_out[g])
        );
    end

    // The merge stage takes the largest surface and turns it into value and priority.
    bte_merge u_merge (
        .clk       (clk),
        .lanes     (lane_out),
        .prio_low  (prio_low_reg),
        .prio_span (prio_span_reg),
        .value     (value_out),
        .prio      (priority_out),
        .side      (side),
        .grad      (grad)
    );

    assign side_x         = side[0];
    assign side_y         = side[1];
    assign side_z         = side[2];
    assign vel_gradient_x = grad[0];
    assign vel_gradient_y = grad[1];
    assign vel_gradient_z = grad[2];

endmodule

`default_nettype wire
